### rtl/lbpdt_pkg.sv
// Shared types and codes for the buffer pool page tracker.
package lbpdt_pkg;

   localparam int ENTRIES = 8;
   localparam int PAGE_ID_BITS = 32;
   localparam int ACTION_BITS = 2;
   localparam int KIND_BITS = 3;
   localparam int SLOT_BITS = 3;
   localparam int CAP_BITS = 4;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_FETCH = 2'd0,
      ACT_MARK  = 2'd1,
      ACT_FLUSH = 2'd2,
      ACT_ALL   = 2'd3
   } action_type;

   localparam logic [KIND_BITS-1:0] K_HIT      = 3'd0;
   localparam logic [KIND_BITS-1:0] K_LOAD     = 3'd1;
   localparam logic [KIND_BITS-1:0] K_WB       = 3'd2;
   localparam logic [KIND_BITS-1:0] K_DONE     = 3'd3;
   localparam logic [KIND_BITS-1:0] K_NOTFOUND = 3'd4;
   localparam logic [KIND_BITS-1:0] K_CLEAN    = 3'd5;

endpackage

### rtl/lru_buffer_pool_dirty_tracker_unit.sv
// Top level of the LRU buffer pool page tracker with dirty writeback.
//
//  channel | dir | payload
//  req_    | in  | tdata = action[1:0], page_number[33:2], zero fill to 40 bits
//  rsp_    | out | tuser = kind[2:0]; tdata = page_out[31:0], slot[34:32]; tlast = last
//  csr_    | in  | pool_capacity[3:0]
//
// A request is taken while the unit is idle; the tag memory is then read one slot
// per cycle in a walk over all ENTRIES slots, held only while a flush-all writeback
// waits for the output. A new request waits until the last result is registered.
// A single output register holds each result until it is transferred.
// Reset is synchronous and clears valid, dirty, rank and occupancy at once.
module lru_buffer_pool_dirty_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action, page_number, zero fill
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,   // page_out, slot, zero fill
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   localparam int ENTRIES = lbpdt_pkg::ENTRIES;
   localparam int PAGE_ID_BITS = lbpdt_pkg::PAGE_ID_BITS;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_DEC   = 6'b000100,
      S_EVRD  = 6'b001000,
      S_EMIT  = 6'b010000,
      S_WAIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [PAGE_ID_BITS-1:0] tag_mem [ENTRIES];
   logic [PAGE_ID_BITS-1:0] rd_ff;
   logic [ENTRIES-1:0] valid_ff, dirty_ff;
   logic [IW-1:0] rank_ff [ENTRIES];
   logic [CW-1:0] occ_ff;
   logic [3:0] cap_ff;

   lbpdt_pkg::action_type act_ff;
   logic [PAGE_ID_BITS-1:0] page_ff;
   logic [IW:0] idx_ff;         // scan index, holds ENTRIES at end
   logic hit_ff;
   logic [IW-1:0] hit_slot_ff;
   logic [IW-1:0] victim_ff;

   logic o_valid_ff, o_last_ff;
   logic [2:0] o_kind_ff;
   logic [PAGE_ID_BITS-1:0] o_page_ff;
   logic [IW-1:0] o_slot_ff;

   logic [3:0] cap_eff;
   logic [IW-1:0] idx_lo;
   logic out_free;
   logic need_evict;
   logic dec_miss;
   logic scan_step;
   logic rd_en;
   logic [IW-1:0] rd_idx;
   logic wr_en;
   logic [IW-1:0] wr_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free = !o_valid_ff || rsp_tready;
   assign idx_lo = idx_ff[IW-1:0];

   always_comb begin
      cap_eff = cap_ff;
      if (cap_ff == 4'd0) cap_eff = 4'd1;
      if (32'(cap_eff) > ENTRIES) cap_eff = 4'(ENTRIES);
   end

   // LRU victim: highest rank among valid slots, last one on ties.
   logic [IW-1:0] lru_slot;
   always_comb begin
      logic [IW-1:0] best;
      best = '0;
      lru_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && rank_ff[i] >= best) begin
            lru_slot = IW'(i);
            best = rank_ff[i];
         end
      end
   end

   logic [IW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (!valid_ff[i]) free_slot = IW'(i);
   end

   assign need_evict = (occ_ff != '0) && (32'(occ_ff) >= 32'(cap_eff));
   assign dec_miss = (state_ff == S_DEC) && out_free
                     && (act_ff == lbpdt_pkg::ACT_FETCH) && !hit_ff;
   // The loaded tag is written at the decision edge, so the next walk reads it.
   assign wr_en = dec_miss && !need_evict;
   assign wr_idx = free_slot;

   // The walk advances unless a flush-all writeback waits for the output.
   always_comb begin
      scan_step = 1'b0;
      if (idx_ff != (IW+1)'(ENTRIES))
         scan_step = !(act_ff == lbpdt_pkg::ACT_ALL && valid_ff[idx_lo]
                       && dirty_ff[idx_lo] && !out_free);
   end

   // Reads run ahead: slot 0 on a request, the next slot in the walk, the LRU victim.
   always_comb begin
      rd_en = 1'b0;
      rd_idx = '0;
      if (state_ff == S_IDLE) begin
         rd_en = req_tvalid;
      end else if (state_ff == S_SCAN) begin
         rd_en = scan_step && (32'(idx_ff) + 1 < ENTRIES);
         rd_idx = IW'(idx_ff + 1'b1);
      end else if (state_ff == S_DEC) begin
         rd_en = dec_miss && need_evict;
         rd_idx = lru_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= tag_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr_en) tag_mem[wr_idx] <= page_ff;
   end

   logic [39:0] req_pad;
   assign req_pad = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
         occ_ff <= '0;
         cap_ff <= 4'd8;
         o_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) cap_ff <= csr_data;
         if (rsp_tready) o_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               act_ff <= lbpdt_pkg::action_type'(req_pad[1:0]);
               page_ff <= PAGE_ID_BITS'(req_pad[33:2]);
               idx_ff <= '0;
               hit_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // rd_ff holds tag of slot idx_lo.
               if (idx_ff != (IW+1)'(ENTRIES)) begin
                  if (act_ff == lbpdt_pkg::ACT_ALL) begin
                     if (valid_ff[idx_lo] && dirty_ff[idx_lo]) begin
                        if (out_free) begin
                           dirty_ff[idx_lo] <= 1'b0;
                           o_valid_ff <= 1'b1;
                           o_kind_ff <= lbpdt_pkg::K_WB;
                           o_page_ff <= rd_ff;
                           o_slot_ff <= idx_lo;
                           o_last_ff <= 1'b0;
                           idx_ff <= idx_ff + 1'b1;
                        end
                     end else begin
                        idx_ff <= idx_ff + 1'b1;
                     end
                  end else begin
                     if (valid_ff[idx_lo] && rd_ff == page_ff && !hit_ff) begin
                        hit_ff <= 1'b1;
                        hit_slot_ff <= idx_lo;
                     end
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_DEC;
               end
            end
            S_DEC: if (out_free) begin
               o_page_ff <= page_ff;
               o_last_ff <= 1'b1;
               unique case (act_ff)
                  lbpdt_pkg::ACT_ALL: begin
                     o_valid_ff <= 1'b1;
                     o_kind_ff <= lbpdt_pkg::K_DONE;
                     o_page_ff <= '0;
                     o_slot_ff <= '0;
                     state_ff <= S_IDLE;
                  end
                  lbpdt_pkg::ACT_MARK: begin
                     o_valid_ff <= 1'b1;
                     o_kind_ff <= hit_ff ? lbpdt_pkg::K_DONE : lbpdt_pkg::K_NOTFOUND;
                     o_slot_ff <= hit_ff ? hit_slot_ff : '0;
                     if (hit_ff) dirty_ff[hit_slot_ff] <= 1'b1;
                     state_ff <= S_IDLE;
                  end
                  lbpdt_pkg::ACT_FLUSH: begin
                     o_valid_ff <= 1'b1;
                     o_slot_ff <= hit_ff ? hit_slot_ff : '0;
                     if (!hit_ff) o_kind_ff <= lbpdt_pkg::K_NOTFOUND;
                     else if (dirty_ff[hit_slot_ff]) o_kind_ff <= lbpdt_pkg::K_WB;
                     else o_kind_ff <= lbpdt_pkg::K_CLEAN;
                     if (hit_ff) dirty_ff[hit_slot_ff] <= 1'b0;
                     state_ff <= S_IDLE;
                  end
                  lbpdt_pkg::ACT_FETCH: begin
                     if (hit_ff) begin
                        for (int i = 0; i < ENTRIES; i++)
                           if (valid_ff[i] && rank_ff[i] < rank_ff[hit_slot_ff])
                              rank_ff[i] <= rank_ff[i] + 1'b1;
                        rank_ff[hit_slot_ff] <= '0;
                        o_valid_ff <= 1'b1;
                        o_kind_ff <= lbpdt_pkg::K_HIT;
                        o_slot_ff <= hit_slot_ff;
                        state_ff <= S_IDLE;
                     end else if (need_evict) begin
                        victim_ff <= lru_slot;
                        state_ff <= S_EVRD;
                     end else begin
                        for (int i = 0; i < ENTRIES; i++)
                           if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + 1'b1;
                        rank_ff[free_slot] <= '0;
                        valid_ff[free_slot] <= 1'b1;
                        dirty_ff[free_slot] <= 1'b0;
                        occ_ff <= occ_ff + 1'b1;
                        o_valid_ff <= 1'b1;
                        o_kind_ff <= lbpdt_pkg::K_LOAD;
                        o_slot_ff <= free_slot;
                        state_ff <= S_IDLE;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_EVRD: state_ff <= S_EMIT;
            S_EMIT: if (out_free) begin
               if (dirty_ff[victim_ff]) begin
                  o_valid_ff <= 1'b1;
                  o_kind_ff <= lbpdt_pkg::K_WB;
                  o_page_ff <= rd_ff;
                  o_slot_ff <= victim_ff;
                  o_last_ff <= 1'b0;
               end
               valid_ff[victim_ff] <= 1'b0;
               dirty_ff[victim_ff] <= 1'b0;
               rank_ff[victim_ff] <= '0;
               occ_ff <= occ_ff - 1'b1;
               state_ff <= S_WAIT;
            end
            S_WAIT: state_ff <= S_DEC;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tlast = o_last_ff;
   assign rsp_tuser = o_kind_ff;
   assign rsp_tdata = {5'b0, 3'(o_slot_ff), 32'(o_page_ff)};

   logic unused_ok;
   assign unused_ok = ^req_pad[39:34];

endmodule

### rtl/lbpdt_checker.sv
// Port checker for the buffer pool page tracker, bound to the top level.
module lbpdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= lbpdt_pkg::K_CLEAN)
      else $error("bad result kind");

   a_nonlast_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == lbpdt_pkg::K_WB)
      else $error("only writebacks may precede the final result");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind lru_buffer_pool_dirty_tracker_unit lbpdt_checker u_lbpdt_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);

### test/lru_buffer_pool_dirty_tracker_unit_checker.sv
// Checker for the buffer pool page tracker: predicts results and compares transfers.
module lru_buffer_pool_dirty_tracker_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // action, page_number, zero fill
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // page_out, slot, zero fill
   input  logic [2:0]  rsp_tuser,   // kind
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS = 8;

   typedef struct packed {
      logic [lbpdt_pkg::KIND_BITS-1:0] kind;
      logic [31:0]                     page;
      logic [lbpdt_pkg::SLOT_BITS-1:0] slot;
      logic                            last;
   } page_result_type;

   page_result_type expected_results[$];

   logic [3:0]  capacity_reg;
   logic [31:0] tag_q [NSLOTS];
   logic        valid_q [NSLOTS];
   logic        dirty_q [NSLOTS];
   int unsigned rank_q [NSLOTS];
   int unsigned resident;

   function automatic page_result_type make_result(logic [lbpdt_pkg::KIND_BITS-1:0] k,
                                                   logic [31:0] p, int s, logic l);
      page_result_type r;
      r.kind = k;
      r.page = p;
      r.slot = s[lbpdt_pkg::SLOT_BITS-1:0];
      r.last = l;
      return r;
   endfunction

   function automatic int find_page(logic [31:0] p);
      for (int i = 0; i < NSLOTS; i++)
         if (valid_q[i] && tag_q[i] == p) return i;
      return -1;
   endfunction

   task automatic evict_lru();
      int victim;
      int unsigned best;
      victim = -1;
      best = 0;
      for (int i = 0; i < NSLOTS; i++)
         if (valid_q[i] && rank_q[i] + 1 == resident) victim = i;
      if (victim < 0)
         for (int i = 0; i < NSLOTS; i++)
            if (valid_q[i] && (victim < 0 || rank_q[i] >= best)) begin
               victim = i;
               best = rank_q[i];
            end
      if (victim < 0) return;
      if (dirty_q[victim])
         expected_results.push_back(make_result(lbpdt_pkg::K_WB, tag_q[victim], victim,
                                                1'b0));
      valid_q[victim] = 1'b0;
      dirty_q[victim] = 1'b0;
      rank_q[victim] = 0;
      resident--;
   endtask

   task automatic predict_request(lbpdt_pkg::action_type act, logic [31:0] p);
      int s;
      int unsigned cap;
      int unsigned r;
      s = find_page(p);
      case (act)
         lbpdt_pkg::ACT_FETCH: begin
            if (s >= 0) begin
               r = rank_q[s];
               for (int i = 0; i < NSLOTS; i++)
                  if (valid_q[i] && rank_q[i] < r) rank_q[i]++;
               rank_q[s] = 0;
               expected_results.push_back(make_result(lbpdt_pkg::K_HIT, p, s, 1'b1));
            end else begin
               cap = (capacity_reg < 1) ? 1 : (capacity_reg > NSLOTS ? NSLOTS : capacity_reg);
               while (resident > 0 && resident >= cap) evict_lru();
               for (int i = 0; i < NSLOTS; i++)
                  if (!valid_q[i] && s < 0) s = i;
               if (s < 0) s = 0;
               for (int i = 0; i < NSLOTS; i++)
                  if (valid_q[i]) rank_q[i]++;
               tag_q[s] = p;
               valid_q[s] = 1'b1;
               dirty_q[s] = 1'b0;
               rank_q[s] = 0;
               resident++;
               expected_results.push_back(make_result(lbpdt_pkg::K_LOAD, p, s, 1'b1));
            end
         end
         lbpdt_pkg::ACT_MARK: begin
            if (s >= 0) begin
               dirty_q[s] = 1'b1;
               expected_results.push_back(make_result(lbpdt_pkg::K_DONE, p, s, 1'b1));
            end else
               expected_results.push_back(make_result(lbpdt_pkg::K_NOTFOUND, p, 0, 1'b1));
         end
         lbpdt_pkg::ACT_FLUSH: begin
            if (s < 0)
               expected_results.push_back(make_result(lbpdt_pkg::K_NOTFOUND, p, 0, 1'b1));
            else if (dirty_q[s]) begin
               dirty_q[s] = 1'b0;
               expected_results.push_back(make_result(lbpdt_pkg::K_WB, p, s, 1'b1));
            end else
               expected_results.push_back(make_result(lbpdt_pkg::K_CLEAN, p, s, 1'b1));
         end
         default: begin
            for (int i = 0; i < NSLOTS; i++)
               if (valid_q[i] && dirty_q[i]) begin
                  dirty_q[i] = 1'b0;
                  expected_results.push_back(make_result(lbpdt_pkg::K_WB, tag_q[i], i,
                                                         1'b0));
               end
            expected_results.push_back(make_result(lbpdt_pkg::K_DONE, 32'd0, 0, 1'b1));
         end
      endcase
   endtask

   task automatic report_mismatch(string what, page_result_type want,
                                  page_result_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected kind %0d page %h slot %0d last %0b,%s",
                  $realtime, what, want.kind, want.page, want.slot, want.last,
                  $sformatf(" got kind %0d page %h slot %0d last %0b",
                            got.kind, got.page, got.slot, got.last));
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      page_result_type got;
      page_result_type want;
      if (reset) begin
         capacity_reg = 4'd8;
         resident = 0;
         for (int i = 0; i < NSLOTS; i++) begin
            valid_q[i] = 1'b0;
            dirty_q[i] = 1'b0;
            rank_q[i] = 0;
            tag_q[i] = '0;
         end
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) capacity_reg = csr_data;
         if (req_tvalid && req_tready)
            predict_request(lbpdt_pkg::action_type'(req_tdata[1:0]), req_tdata[33:2]);
         if (rsp_tvalid && rsp_tready) begin
            got = make_result(rsp_tuser, rsp_tdata[31:0], int'(rsp_tdata[34:32]), rsp_tlast);
            if (expected_results.size() == 0) begin
               want = '0;
               report_mismatch("unexpected result", want, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) report_mismatch("result mismatch", want, got);
            end
         end
      end
      pending_count = expected_results.size();
   end
endmodule

### test/lru_buffer_pool_dirty_tracker_unit_tb.sv
// Testbench top for the buffer pool page tracker: stimulus, idling phases and verdict.
module lru_buffer_pool_dirty_tracker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // action, page_number, zero fill
   logic        rsp_tready = 1'b0;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;        // page_out, slot, zero fill
   logic [2:0]  rsp_tuser;        // kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [31:0] page_pool [16];

   always #6 clock = ~clock;

   lru_buffer_pool_dirty_tracker_unit dut (.*);

   lru_buffer_pool_dirty_tracker_unit_checker checker_i (.*);

   // The receiver stalls at random; the rate follows the current phase.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Each call starts at a fresh falling edge, so valid is never driven twice at once.
   task automatic send_request(lbpdt_pkg::action_type act, logic [31:0] page);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tdata <= {6'd0, page, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_capacity(logic [3:0] value);
      drain_results();
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly pages from a small pool so hits, dirty marks and evictions happen.
   task automatic random_request();
      lbpdt_pkg::action_type act;
      logic [31:0] page;
      int pick;
      pick = $urandom_range(99);
      act = pick < 55 ? lbpdt_pkg::ACT_FETCH : pick < 75 ? lbpdt_pkg::ACT_MARK :
            pick < 92 ? lbpdt_pkg::ACT_FLUSH : lbpdt_pkg::ACT_ALL;
      page = ($urandom_range(9) == 0) ? $urandom() : page_pool[$urandom_range(15)];
      send_request(act, page);
   endtask

   initial begin
      logic [3:0] caps [6];
      caps = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5};
      for (int i = 0; i < 16; i++) page_pool[i] = $urandom();
      page_pool[0] = 32'h0;
      page_pool[1] = 32'hFFFF_FFFF;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: extreme pages, every action, evictions of clean and dirty pages.
      write_capacity(4'd2);
      send_request(lbpdt_pkg::ACT_MARK, 32'h0);
      send_request(lbpdt_pkg::ACT_FLUSH, 32'hFFFF_FFFF);
      send_request(lbpdt_pkg::ACT_ALL, 32'h0);
      send_request(lbpdt_pkg::ACT_FETCH, 32'h0);
      send_request(lbpdt_pkg::ACT_FETCH, 32'hFFFF_FFFF);
      send_request(lbpdt_pkg::ACT_FETCH, 32'h0);
      send_request(lbpdt_pkg::ACT_MARK, 32'h0);
      send_request(lbpdt_pkg::ACT_MARK, 32'hFFFF_FFFF);
      send_request(lbpdt_pkg::ACT_FLUSH, 32'h0);
      send_request(lbpdt_pkg::ACT_FLUSH, 32'h0);
      send_request(lbpdt_pkg::ACT_MARK, 32'h0);
      send_request(lbpdt_pkg::ACT_FETCH, 32'h5555_AAAA);
      send_request(lbpdt_pkg::ACT_FETCH, 32'hAAAA_5555);
      send_request(lbpdt_pkg::ACT_ALL, 32'h1234_5678);
      write_capacity(4'd8);
      for (int i = 0; i < 8; i++) begin
         send_request(lbpdt_pkg::ACT_FETCH, 32'h100 + i);
         send_request(lbpdt_pkg::ACT_MARK, 32'h100 + i);
      end
      send_request(lbpdt_pkg::ACT_FETCH, 32'h200);
      // Shrinking capacity forces several writebacks on one miss.
      write_capacity(4'd1);
      send_request(lbpdt_pkg::ACT_FETCH, 32'h300);

      for (int ph = 0; ph < 6; ph++) begin
         write_capacity(caps[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int n = 0; n < 60; n++) random_request();
         // In phase 2, pause until every expected result is back before carrying on.
         if (ph == 2) while (pending_count != 0) @(negedge clock);
         for (int n = 0; n < 5; n++) random_request();
      end
      drain_results();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
